>>> rtl/chd_pkg.sv
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types, constants and filter coefficients of the horizontal chroma
// decimator.
// ----------------------------------------------------------------------------
package chd_pkg;

  // Field and register widths.
  localparam int unsigned SampleW = 8;
  localparam int unsigned CfgW    = 13;
  localparam int unsigned IdxW    = 2;
  localparam int unsigned ExtW    = 14;   // width of clamp arithmetic on counters

  // Sample window and one-hot-free helper widths.
  localparam int unsigned WinDepth = 12;
  localparam int unsigned OffW     = 4;

  // Result queue.
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = PtrW + 1;
  localparam int unsigned Lanes     = 3;

  // Parameter defaults.
  localparam int unsigned MaxRowLengthDef = 4096;
  localparam int unsigned MaxRowsDef      = 4096;

  // Register reset values.
  localparam logic [CfgW-1:0] RowLengthRst  = CfgW'(720);
  localparam logic [CfgW-1:0] RowsRst       = CfgW'(576);
  localparam logic            FilterModeRst = 1'b0;

  // Smallest usable row length.
  localparam int unsigned MinRowLength = 8;

  // Filter arithmetic.
  localparam int unsigned AccW = 20;
  localparam logic signed [AccW-1:0] K228  = AccW'(228);
  localparam logic signed [AccW-1:0] K70   = AccW'(70);
  localparam logic signed [AccW-1:0] K37   = AccW'(37);
  localparam logic signed [AccW-1:0] K21   = AccW'(21);
  localparam logic signed [AccW-1:0] K11   = AccW'(11);
  localparam logic signed [AccW-1:0] K5    = AccW'(5);
  localparam logic signed [AccW-1:0] K22   = AccW'(22);
  localparam logic signed [AccW-1:0] K52   = AccW'(52);
  localparam logic signed [AccW-1:0] K159  = AccW'(159);
  localparam logic signed [AccW-1:0] K256  = AccW'(256);
  localparam logic signed [AccW-1:0] Round = AccW'(256);
  localparam int unsigned            Shift = 9;

  // Reach of the filter to the right of the output column.
  localparam logic [OffW-1:0] ReachHalfPhase = OffW'(6);
  localparam logic [OffW-1:0] ReachCosited   = OffW'(5);
  localparam logic [OffW-1:0] ReachFlush1    = OffW'(3);
  localparam logic [OffW-1:0] ReachFlush2    = OffW'(1);

  // Configuration register indexes.
  typedef enum logic [IdxW-1:0] {
    CFG_ROW_LENGTH  = 2'd0,
    CFG_ROWS        = 2'd1,
    CFG_FILTER_MODE = 2'd2
  } cfg_idx_e;

  // Newest sample at index 0.
  typedef logic [WinDepth-1:0][SampleW-1:0] win_t;

  // One result item.
  typedef struct packed {
    logic [SampleW-1:0] chroma;
    logic               row_end;
    logic               frame_end;
  } res_t;

  typedef res_t [Lanes-1:0] res_vec_t;

  // Item waiting in the filter stage.
  typedef struct packed {
    logic [1:0]      cnt;        // results it produces: 0, 1 or 3
    logic            mode;
    logic            row_last;
    logic            frame_last;
    logic [OffW-1:0] col;        // column, saturated
  } pend_t;

endpackage

>>> rtl/chd_fir.sv
// ----------------------------------------------------------------------------
// chd_fir
// One filter lane: picks the taps out of the sample window with edge
// replication, forms the weighted sum and rounds and clips it.
// ----------------------------------------------------------------------------
module chd_fir (
  input  chd_pkg::win_t                    win_i,
  input  logic                             mode_i,
  input  logic [chd_pkg::OffW-1:0]         reach_i,
  input  logic [chd_pkg::OffW-1:0]         col_i,
  output logic [chd_pkg::SampleW-1:0]      chroma_o
);

  logic [chd_pkg::OffW-1:0]    off   [chd_pkg::WinDepth];
  logic [chd_pkg::SampleW-1:0] tap   [chd_pkg::WinDepth];
  logic signed [chd_pkg::AccW-1:0] sum_half, sum_cos, sum_sel, sum_rnd;
  logic [chd_pkg::AccW-chd_pkg::Shift-1:0] quot;

  function automatic logic signed [chd_pkg::AccW-1:0] pair(
    input logic [chd_pkg::SampleW-1:0] a,
    input logic [chd_pkg::SampleW-1:0] b
  );
    logic [chd_pkg::SampleW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return $signed(chd_pkg::AccW'(s));
  endfunction

  // Tap j sits at column i + j - 5. A tap right of the newest sample repeats
  // the last sample of the row; one left of the row start repeats column 0.
  always_comb begin
    for (int j = 0; j < chd_pkg::WinDepth; j++) begin
      if (5'(j) > {1'b0, reach_i} + 5'd5) begin
        off[j] = '0;
      end else if ({1'b0, col_i} + 5'(j) < {1'b0, reach_i} + 5'd5) begin
        off[j] = col_i;
      end else begin
        off[j] = chd_pkg::OffW'(reach_i + 4'd5 - 4'(j));
      end
      tap[j] = win_i[off[j]];
    end
  end

  always_comb begin
    sum_half = chd_pkg::K228 * pair(tap[5], tap[6])
             + chd_pkg::K70  * pair(tap[4], tap[7])
             - chd_pkg::K37  * pair(tap[3], tap[8])
             - chd_pkg::K21  * pair(tap[2], tap[9])
             + chd_pkg::K11  * pair(tap[1], tap[10])
             + chd_pkg::K5   * pair(tap[0], tap[11]);
    sum_cos  = chd_pkg::K22  * pair(tap[0], tap[10])
             - chd_pkg::K52  * pair(tap[2], tap[8])
             + chd_pkg::K159 * pair(tap[4], tap[6])
             + chd_pkg::K256 * pair(tap[5], '0);
    sum_sel  = mode_i ? sum_half : sum_cos;
    sum_rnd  = sum_sel + chd_pkg::Round;
    quot     = sum_rnd[chd_pkg::AccW-1:chd_pkg::Shift];
    if (sum_rnd[chd_pkg::AccW-1]) begin
      chroma_o = '0;
    end else if (quot > (chd_pkg::AccW-chd_pkg::Shift)'(255)) begin
      chroma_o = '1;
    end else begin
      chroma_o = quot[chd_pkg::SampleW-1:0];
    end
  end

endmodule

>>> rtl/chd_res_fifo.sv
// ----------------------------------------------------------------------------
// chd_res_fifo
// Result queue: takes up to three results a cycle in order, gives one.
// ----------------------------------------------------------------------------
module chd_res_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [1:0]                  push_cnt_i,
  input  chd_pkg::res_vec_t           push_data_i,
  input  logic                        pop_i,
  output logic [chd_pkg::CntW-1:0]    count_o,
  output logic                        valid_o,
  output chd_pkg::res_t               head_o
);

  chd_pkg::res_t mem_q [chd_pkg::FifoDepth];
  logic [chd_pkg::PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [chd_pkg::CntW-1:0] count_q, count_d;
  logic                     pop;

  assign pop     = pop_i && (count_q != '0);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q + chd_pkg::PtrW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + chd_pkg::PtrW'(pop);
    count_d  = count_q + chd_pkg::CntW'(push_cnt_i) - chd_pkg::CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < chd_pkg::Lanes; k++) begin
      if (2'(k) < push_cnt_i) begin
        mem_q[wr_ptr_q + chd_pkg::PtrW'(k)] <= push_data_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> rtl/chroma_horizontal_decimator.sv
// ----------------------------------------------------------------------------
// chroma_horizontal_decimator
// Horizontal 2:1 chroma decimation (4:4:4 to 4:2:2) with edge replication.
// ----------------------------------------------------------------------------
// Usage. Chroma samples enter in row-major order on the sample channel
// (in_valid_i / in_stall_o / sample_i); each accepted item is one sample.
// Filtered samples leave on the result channel (out_valid_o / out_stall_i)
// with chroma_o, row_end_o on the last result of a row and frame_end_o on
// the last result of a frame. Each row of W samples gives W/2 results.
// Registers are written on the configuration channel (cfg_valid_i /
// cfg_ready_o); a write to any of the three registers restarts the row and
// frame position, and a write to an index past the list is ignored.
// Throughput is one sample per cycle. The filter of every result is one
// registered pass: the sample window is the input register and a small
// result queue the output register, so a sample is registered in the
// window and its results in the queue. The last sample of a row completes
// three results at once; the eight-entry queue absorbs them, and the input
// is stalled only while the queue could not take three more results, which
// happens only when the receiver stalls. After reset the registers hold
// their reset values, the window is cleared and the position is row 0,
// column 0.
// ----------------------------------------------------------------------------
module chroma_horizontal_decimator #(
  parameter int unsigned MAX_ROW_LENGTH = chd_pkg::MaxRowLengthDef,
  parameter int unsigned MAX_ROWS       = chd_pkg::MaxRowsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Sample channel.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [chd_pkg::SampleW-1:0]     sample_i,
  // Result channel.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [chd_pkg::SampleW-1:0]     chroma_o,
  output logic                            row_end_o,
  output logic                            frame_end_o,
  // Configuration channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [chd_pkg::IdxW-1:0]        cfg_index_i,
  input  logic [chd_pkg::CfgW-1:0]        cfg_data_i
);

  localparam int unsigned ColW = $clog2(MAX_ROW_LENGTH);
  localparam int unsigned RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // Configuration registers.
  logic [chd_pkg::CfgW-1:0] row_length_q, rows_q;
  logic                     mode_q;
  logic                     cfg_write;

  // Position and window.
  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  chd_pkg::win_t     win_q, win_d;
  chd_pkg::pend_t    pend_q, pend_d;

  // Derived row geometry.
  logic [chd_pkg::ExtW-1:0] len_ext, width_eff, rows_ext, rows_eff, col_ext, row_ext;
  logic                     last_col, last_row;
  logic [chd_pkg::OffW-1:0] reach, col_sat;
  logic                     in_acc, out_acc;

  // Filter lanes and result queue.
  logic [chd_pkg::OffW-1:0]    lane_reach [chd_pkg::Lanes];
  logic [chd_pkg::SampleW-1:0] lane_chroma [chd_pkg::Lanes];
  chd_pkg::res_vec_t           push_data;
  logic [1:0]                  push_cnt;
  logic [chd_pkg::CntW-1:0]    fifo_count;
  logic [chd_pkg::CntW:0]      fill_need;
  chd_pkg::res_t               head;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // Row length is clamped to the supported range with its lowest bit
  // cleared; the row count per frame is clamped to one through MAX_ROWS.
  always_comb begin
    len_ext = chd_pkg::ExtW'(row_length_q);
    if (len_ext < chd_pkg::ExtW'(chd_pkg::MinRowLength)) begin
      width_eff = chd_pkg::ExtW'(chd_pkg::MinRowLength);
    end else if (len_ext > chd_pkg::ExtW'(MAX_ROW_LENGTH)) begin
      width_eff = chd_pkg::ExtW'(MAX_ROW_LENGTH);
    end else begin
      width_eff = len_ext;
    end
    width_eff[0] = 1'b0;

    rows_ext = chd_pkg::ExtW'(rows_q);
    if (rows_ext < chd_pkg::ExtW'(1)) begin
      rows_eff = chd_pkg::ExtW'(1);
    end else if (rows_ext > chd_pkg::ExtW'(MAX_ROWS)) begin
      rows_eff = chd_pkg::ExtW'(MAX_ROWS);
    end else begin
      rows_eff = rows_ext;
    end

    col_ext  = chd_pkg::ExtW'(col_q);
    row_ext  = chd_pkg::ExtW'(row_q);
    last_col = (col_ext == width_eff - chd_pkg::ExtW'(1));
    last_row = (row_ext + chd_pkg::ExtW'(1) >= rows_eff);
    col_sat  = (col_ext > chd_pkg::ExtW'(15)) ? '1 : chd_pkg::OffW'(col_ext);
    reach    = mode_q ? chd_pkg::ReachHalfPhase : chd_pkg::ReachCosited;
  end

  // Queue space: the item in the filter stage and a new one may each add
  // up to three results; pops are not counted, which keeps this safe.
  always_comb begin
    fill_need  = {1'b0, fifo_count} + (chd_pkg::CntW+1)'(push_cnt)
               + (chd_pkg::CntW+1)'(chd_pkg::Lanes);
    in_stall_o = (fill_need > (chd_pkg::CntW+1)'(chd_pkg::FifoDepth));
  end

  assign in_acc = in_valid_i && !in_stall_o;

  // Accepting a sample shifts it into the window and records which results
  // it completes. Inside a row one result is due whenever the filter's
  // right reach lands on the new sample at an even output column; the last
  // sample of a row completes the three rightmost results.
  always_comb begin
    win_d  = win_q;
    col_d  = col_q;
    row_d  = row_q;
    pend_d = pend_q;
    pend_d.cnt = 2'd0;
    if (in_acc) begin
      win_d = {win_q[chd_pkg::WinDepth-2:0], sample_i};
      pend_d.mode       = mode_q;
      pend_d.row_last   = last_col;
      pend_d.frame_last = last_row;
      pend_d.col        = col_sat;
      if (last_col) begin
        pend_d.cnt = 2'd3;
        col_d      = '0;
        row_d      = last_row ? '0 : row_q + 1'b1;
      end else begin
        if ((col_ext >= chd_pkg::ExtW'(reach)) && (col_q[0] == reach[0])) begin
          pend_d.cnt = 2'd1;
        end
        col_d = col_q + 1'b1;
      end
    end
    // Only a write that lands on one of the registers restarts the position.
    if (cfg_write) begin
      case (cfg_index_i)
        chd_pkg::CFG_ROW_LENGTH, chd_pkg::CFG_ROWS, chd_pkg::CFG_FILTER_MODE: begin
          col_d = '0;
          row_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= chd_pkg::RowLengthRst;
      rows_q       <= chd_pkg::RowsRst;
      mode_q       <= chd_pkg::FilterModeRst;
    end else if (cfg_write) begin
      case (cfg_index_i)
        chd_pkg::CFG_ROW_LENGTH:  row_length_q <= cfg_data_i;
        chd_pkg::CFG_ROWS:        rows_q       <= cfg_data_i;
        chd_pkg::CFG_FILTER_MODE: mode_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      win_q  <= '0;
      pend_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      win_q  <= win_d;
      pend_q <= pend_d;
    end
  end

  // Lane 0 gives the regular result; at the row end the three lanes give
  // the results for the last three even columns, left to right.
  always_comb begin
    lane_reach[0] = (pend_q.mode && !pend_q.row_last) ? chd_pkg::ReachHalfPhase
                                                      : chd_pkg::ReachCosited;
    lane_reach[1] = chd_pkg::ReachFlush1;
    lane_reach[2] = chd_pkg::ReachFlush2;
  end

  for (genvar g = 0; g < chd_pkg::Lanes; g++) begin : g_lane
    chd_fir u_fir (
      .win_i    (win_q),
      .mode_i   (pend_q.mode),
      .reach_i  (lane_reach[g]),
      .col_i    (pend_q.col),
      .chroma_o (lane_chroma[g])
    );
  end

  always_comb begin
    push_cnt = pend_q.cnt;
    for (int k = 0; k < chd_pkg::Lanes; k++) begin
      push_data[k].chroma    = lane_chroma[k];
      push_data[k].row_end   = 1'b0;
      push_data[k].frame_end = 1'b0;
    end
    push_data[chd_pkg::Lanes-1].row_end   = pend_q.row_last;
    push_data[chd_pkg::Lanes-1].frame_end = pend_q.row_last && pend_q.frame_last;
  end

  assign out_acc = out_valid_o && !out_stall_i;

  chd_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push_data_i (push_data),
    .pop_i       (out_acc),
    .count_o     (fifo_count),
    .valid_o     (out_valid_o),
    .head_o      (head)
  );

  assign chroma_o    = head.chroma;
  assign row_end_o   = head.row_end;
  assign frame_end_o = head.frame_end;

  // The queue never holds more results than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count <= chd_pkg::CntW'(chd_pkg::FifoDepth))
    else $error("result queue overflow");

  // An item at the row end always completes exactly three results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q.cnt != 2'd0) && pend_q.row_last |-> pend_q.cnt == 2'd3)
    else $error("row end without three results");

  // The column position stays inside the row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_ext < width_eff)
    else $error("column beyond row length");

  // A frame ends only on the last result of a row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> row_end_o)
    else $error("frame end without row end");

endmodule

>>> tb/sv/chd_decimation_checker.sv
// ----------------------------------------------------------------------------
// chd_decimation_checker
// Watches the sample, result and register channels of the horizontal chroma
// decimator, predicts every decimated sample with its row and frame flags,
// and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module chd_decimation_checker #(
  parameter int unsigned MAX_ROW_LENGTH = chd_pkg::MaxRowLengthDef,
  parameter int unsigned MAX_ROWS       = chd_pkg::MaxRowsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [chd_pkg::SampleW-1:0] sample_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [chd_pkg::SampleW-1:0] chroma_i,
  input  logic                        row_end_i,
  input  logic                        frame_end_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [chd_pkg::IdxW-1:0]    cfg_index_i,
  input  logic [chd_pkg::CfgW-1:0]    cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [chd_pkg::CfgW-1:0]    row_length_q;
  logic [chd_pkg::CfgW-1:0]    frame_rows_q;
  logic                        half_phase_q;
  logic [chd_pkg::SampleW-1:0] window_q [chd_pkg::WinDepth];
  int                          column_q;
  int                          row_q;
  chd_pkg::res_t               decimated_q [$];
  chd_pkg::res_t               expected_r;

  // Row length in use: clamped to the legal range, lowest bit cleared.
  function automatic int row_width();
    int w;
    w = int'(row_length_q);
    if (w < int'(chd_pkg::MinRowLength)) w = int'(chd_pkg::MinRowLength);
    if (w > int'(MAX_ROW_LENGTH)) w = int'(MAX_ROW_LENGTH);
    return w & ~1;
  endfunction

  function automatic int rows_in_frame();
    int r;
    r = int'(frame_rows_q);
    if (r < 1) r = 1;
    if (r > int'(MAX_ROWS)) r = int'(MAX_ROWS);
    return r;
  endfunction

  // Sample of column k with edge replication, seen from current column c.
  function automatic int tap(int k, int c, int w);
    int off;
    if (k < 0) k = 0;
    if (k > w - 1) k = w - 1;
    off = c - k;
    if (off < 0 || off >= int'(chd_pkg::WinDepth)) return 0;
    return int'(window_q[off]);
  endfunction

  function automatic chd_pkg::res_t filtered(int i, int c, int w);
    int            acc;
    chd_pkg::res_t r;
    if (half_phase_q) begin
      acc = 228 * (tap(i, c, w) + tap(i + 1, c, w))
          + 70 * (tap(i - 1, c, w) + tap(i + 2, c, w))
          - 37 * (tap(i - 2, c, w) + tap(i + 3, c, w))
          - 21 * (tap(i - 3, c, w) + tap(i + 4, c, w))
          + 11 * (tap(i - 4, c, w) + tap(i + 5, c, w))
          + 5 * (tap(i - 5, c, w) + tap(i + 6, c, w));
    end else begin
      acc = 22 * (tap(i - 5, c, w) + tap(i + 5, c, w))
          - 52 * (tap(i - 3, c, w) + tap(i + 3, c, w))
          + 159 * (tap(i - 1, c, w) + tap(i + 1, c, w))
          + 256 * tap(i, c, w);
    end
    acc = acc + 256;
    r = '0;
    if (acc < 0) r.chroma = '0;
    else if ((acc >>> 9) > 255) r.chroma = 8'hFF;
    else r.chroma = chd_pkg::SampleW'(acc >>> 9);
    return r;
  endfunction

  // Shifts one sample in and queues the results it completes; the last
  // sample of a row also flushes the columns whose reach passes the row end.
  task automatic decimate_sample(input logic [chd_pkg::SampleW-1:0] s);
    int            w;
    int            reach;
    int            c;
    int            i;
    int            n;
    chd_pkg::res_t r;
    w = row_width();
    reach = half_phase_q ? 6 : 5;
    if (column_q > w - 1) column_q = 0;
    c = column_q;
    for (int k = chd_pkg::WinDepth - 1; k > 0; k--) window_q[k] = window_q[k-1];
    window_q[0] = s;
    n = 0;
    if (c >= reach && ((c - reach) % 2) == 0) begin
      decimated_q.push_back(filtered(c - reach, c, w));
      n = 1;
    end
    if (c == w - 1) begin
      i = c - reach + 1;
      if (i < 0) i = 0;
      if (i % 2 != 0) i++;
      while (i <= w - 2 && n < 3) begin
        decimated_q.push_back(filtered(i, c, w));
        n++;
        i += 2;
      end
      if (n > 0) begin
        r = decimated_q.pop_back();
        r.row_end = 1'b1;
        r.frame_end = (row_q + 1 >= rows_in_frame());
        decimated_q.push_back(r);
      end
      column_q = 0;
      row_q++;
      if (row_q >= rows_in_frame()) row_q = 0;
    end else begin
      column_q++;
    end
  endtask

  // A write to a known register restarts the position; others are ignored.
  task automatic apply_register(input logic [chd_pkg::IdxW-1:0] idx,
                                input logic [chd_pkg::CfgW-1:0] data);
    logic known;
    known = 1'b1;
    case (chd_pkg::cfg_idx_e'(idx))
      chd_pkg::CFG_ROW_LENGTH:  row_length_q = data;
      chd_pkg::CFG_ROWS:        frame_rows_q = data;
      chd_pkg::CFG_FILTER_MODE: half_phase_q = data[0];
      default:                  known = 1'b0;
    endcase
    if (known) begin
      column_q = 0;
      row_q = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q = chd_pkg::RowLengthRst;
      frame_rows_q = chd_pkg::RowsRst;
      half_phase_q = chd_pkg::FilterModeRst;
      for (int k = 0; k < chd_pkg::WinDepth; k++) window_q[k] = '0;
      column_q = 0;
      row_q = 0;
      decimated_q.delete();
      fail_count_o = 0;
      checked_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (decimated_q.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("[%0t] unexpected result: chroma %0d row_end %0b frame_end %0b",
                     $realtime, chroma_i, row_end_i, frame_end_i);
          end
          fail_count_o++;
        end else begin
          expected_r = decimated_q.pop_front();
          if (expected_r.chroma !== chroma_i || expected_r.row_end !== row_end_i ||
              expected_r.frame_end !== frame_end_i) begin
            if (fail_count_o < 10) begin
              $display("[%0t] result %0d: expected chroma %0d row_end %0b frame_end %0b,",
                       $realtime, checked_o, expected_r.chroma, expected_r.row_end,
                       expected_r.frame_end);
              $display("    got chroma %0d row_end %0b frame_end %0b",
                       chroma_i, row_end_i, frame_end_i);
            end
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) apply_register(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_i) decimate_sample(sample_i);
    end
    pending_o = decimated_q.size();
  end

endmodule

>>> tb/sv/chroma_horizontal_decimator_tb.sv
// ----------------------------------------------------------------------------
// chroma_horizontal_decimator_tb
// Drives chroma samples and register writes into the horizontal decimator
// under several idle and stall profiles, and gives the verdict from the
// failure and pending counts of the checker that sits beside the block.
// ----------------------------------------------------------------------------
module chroma_horizontal_decimator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod = 10;
  // The watchdog fires after this many cycles without any handshake. A
  // correct run never comes near it: the longest quiet spell is the pause
  // before a register write, plus random stall runs.
  localparam int QuietLimit = 2000;
  // Results pass the window and queue registers after their last sample;
  // this margin covers that before a register write and at the end.
  localparam int SettleCycles = 6;
  // The register index past the end of the list, which the block ignores.
  localparam logic [chd_pkg::IdxW-1:0] CfgIdxUnused = 2'd3;

  // Directed rows of eight samples: bit k set means column k is full scale.
  // Half-phase high clip near the left edge.
  localparam logic [7:0] RowHalfClipHigh = 8'h1E;
  // Half-phase low clip where the negative taps see full scale.
  localparam logic [7:0] RowHalfClipLow  = 8'h86;
  // Cosited: high clip at the left edge, low clip in the middle.
  localparam logic [7:0] RowCositedClips = 8'h83;

  typedef enum int {
    PROFILE_FREE,
    PROFILE_SENDER_IDLE,
    PROFILE_RECEIVER_STALL,
    PROFILE_BOTH
  } pace_e;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [chd_pkg::SampleW-1:0] sample = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [chd_pkg::SampleW-1:0] chroma;
  logic                        row_end;
  logic                        frame_end;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [chd_pkg::IdxW-1:0]    cfg_index = '0;
  logic [chd_pkg::CfgW-1:0]    cfg_data = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int samples_sent = 0;
  int register_writes = 0;
  int quiet_cycles = 0;
  int chroma_fails;
  int chroma_pending;
  int chroma_checked;

  always #(ClkPeriod / 2) clk = ~clk;

  chroma_horizontal_decimator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .sample_i    (sample),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .chroma_o    (chroma),
    .row_end_o   (row_end),
    .frame_end_o (frame_end),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  chd_decimation_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .sample_i     (sample),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .chroma_i     (chroma),
    .row_end_i    (row_end),
    .frame_end_i  (frame_end),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (chroma_fails),
    .pending_o    (chroma_pending),
    .checked_o    (chroma_checked)
  );

  // The receiver stalls at random, independently of whether a result is
  // offered, so that stalls land on every phase of a row and its flush.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog: any accepted item, result or register write resets the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Watchdog: no handshake for %0d cycles", QuietLimit);
      $display("chroma_horizontal_decimator verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_pace(input pace_e p);
    case (p)
      PROFILE_SENDER_IDLE: begin
        idle_pct = 52;
        stall_pct = 0;
      end
      PROFILE_RECEIVER_STALL: begin
        idle_pct = 0;
        stall_pct = 52;
      end
      PROFILE_BOTH: begin
        idle_pct = 9;
        stall_pct = 9;
      end
      default: begin
        idle_pct = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  // Full scale and zero turn up often so that the clipping limits are hit.
  function automatic logic [chd_pkg::SampleW-1:0] pick_sample();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return chd_pkg::SampleW'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one sample, possibly after some idle cycles, and holds it until
  // the block takes it. Every call starts on a falling edge of its own, so
  // valid is never lowered and raised in the same step.
  task automatic push_sample(input logic [chd_pkg::SampleW-1:0] value);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
  endtask

  task automatic push_random(input int count);
    repeat (count) push_sample(pick_sample());
  endtask

  task automatic push_pattern_row(input logic [7:0] mask);
    for (int k = 0; k < 8; k++) push_sample(mask[k] ? 8'hFF : 8'h00);
  endtask

  // Stops the sample stream and waits until every predicted result has
  // arrived, then lets the pipeline settle so that the block is idle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chroma_pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [chd_pkg::IdxW-1:0] idx,
                           input logic [chd_pkg::CfgW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    register_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [chd_pkg::CfgW-1:0] length,
                           input logic [chd_pkg::CfgW-1:0] rows,
                           input logic half_phase);
    write_reg(chd_pkg::CFG_ROW_LENGTH, length);
    write_reg(chd_pkg::CFG_ROWS, rows);
    write_reg(chd_pkg::CFG_FILTER_MODE, {{(chd_pkg::CfgW-1){1'b0}}, half_phase});
  endtask

  initial begin
    int unsigned length;
    int unsigned rows;

    // Reset is held at the start and released on a falling edge.
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // The reset settings: 720-sample rows, cosited filter. The row is far
    // too long to finish, so this only checks the steady filter.
    set_pace(PROFILE_FREE);
    push_random(14);
    drain();

    // Directed rows of the shortest length: clipping at both limits in
    // both filters, edge replication at both ends and the three-result
    // flush at every row end. Two rows make a frame in half-phase mode.
    configure(13'd8, 13'd2, 1'b1);
    push_pattern_row(RowHalfClipHigh);
    push_pattern_row(RowHalfClipLow);
    drain();
    configure(13'd8, 13'd1, 1'b0);
    push_pattern_row(RowCositedClips);
    drain();

    // Register extremes: zero length and zero rows clamp to the minimum,
    // so every row ends a frame.
    set_pace(PROFILE_SENDER_IDLE);
    configure('0, '0, 1'b1);
    push_random(12);
    drain();

    // All-ones length and rows clamp to the maximum; the row never ends.
    set_pace(PROFILE_RECEIVER_STALL);
    configure('1, '1, 1'b0);
    push_random(20);
    drain();

    // An odd length drops its lowest bit. Halfway through a row a write to
    // the unused index must leave the position alone.
    set_pace(PROFILE_BOTH);
    configure(13'd11, 13'd3, 1'b1);
    push_random(7);
    drain();
    write_reg(CfgIdxUnused, '1);
    push_random(13);
    drain();

    // Random phases: short rows, mostly whole rows with random content and
    // a partial row cut off by the next register write. In the third phase
    // the sender pauses halfway until every result is out.
    for (int phase = 0; phase < 6; phase++) begin
      set_pace(pace_e'(phase % 4));
      length = 8 + 2 * $urandom_range(0, 8) + (($urandom_range(0, 3) == 0) ? 1 : 0);
      rows = $urandom_range(1, 3);
      configure(chd_pkg::CfgW'(length), chd_pkg::CfgW'(rows), phase[0]);
      if (phase == 2) begin
        push_random(12);
        drain();
        push_random(12);
      end else begin
        push_random(24);
      end
      drain();
    end

    $display("Drove %0d samples and %0d register writes; %0d results checked.",
             samples_sent, register_writes, chroma_checked);
    $display("Both filters, clamped row and frame sizes, row and frame flushes,");
    $display("clipping at both limits, under free, idle, stall and mixed pacing.");
    if (chroma_fails == 0 && chroma_pending == 0) begin
      $display("chroma_horizontal_decimator verification clean");
    end else begin
      $display("%0d failures, %0d results still expected", chroma_fails, chroma_pending);
      $display("chroma_horizontal_decimator verification failed");
    end
    $finish;
  end

endmodule
